// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the stable priority queue
// Entry layout, request and status codes, and the control word that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [15:0] value;
    logic [7:0]  prio;
  } entry_t;

  // broadcast to all cells for the current word
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// File: hdl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares its priority with the incoming word and takes
// the new entry, its left neighbor's entry or its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                prev_le_i,
  input  spq_pkg::entry_t     prev_entry_i,
  input  spq_pkg::entry_t     next_entry_i,
  output spq_pkg::entry_t     entry_o,
  output logic                le_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // occupied and not later than the new word in the order
  assign le_o = occ_i && (entry_q.prio <= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!le_o) begin
        entry_d = prev_le_i ? ctrl_i.new_entry : prev_entry_i;
      end
    end else if (ctrl_i.pop) begin
      // advance toward the head
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/stable_priority_queue.sv
`timescale 1ns / 1ps
// Latency: the done_o strobe is registered from the accepting edge.
// Throughput: one word per cycle; busy stays low, every cell updates in
// the cycle of the accepting edge, and the slot is a one-hot encode.
// Reset: the entry count clears, the queue reads as empty; entries hold
// no reset. The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted command queue built from a chain of cells
// Inserts land after all entries of equal or smaller priority value; pops take the
// head entry. Each accepted word gives one result word.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [1:0]  message_kind_i,
  input  logic [7:0]  command_id_i,
  input  logic [15:0] command_value_i,
  input  logic [7:0]  priority_req_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_command_id_o,
  output logic [15:0] out_command_value_o,
  output logic [7:0]  out_priority_o,
  output logic [4:0]  occupancy_o
);
  import spq_pkg::*;

  localparam int IW  = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = (IW > 4) ? IW : 4;
  localparam int OW  = (CW > 5) ? CW : 5;

  logic              accept;
  logic              full, empty;
  logic [CW-1:0]     count_q, count_d;
  cell_ctrl_t        ctrl;
  entry_t            new_entry;
  entry_t            cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ, le, here;
  logic [IW-1:0]     slot_idx;
  logic [SW-1:0]     slot_ext;
  logic [OW-1:0]     occ_ext;

  logic              done_q;
  status_e           status_q, status_d;
  logic [3:0]        slot_q, slot_d;
  entry_t            out_q, out_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  assign new_entry.kind  = message_kind_i;
  assign new_entry.id    = command_id_i;
  assign new_entry.value = command_value_i;
  assign new_entry.prio  = priority_req_i;

  assign ctrl.ins       = accept && (req_e'(req_type_i) == REQ_INSERT) && !full;
  assign ctrl.pop       = accept && (req_e'(req_type_i) == REQ_POP) && !empty;
  assign ctrl.new_entry = new_entry;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_le;
    entry_t prev_entry, next_entry;

    assign occ[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_le    = 1'b1;
      assign prev_entry = new_entry;
    end else begin : g_body
      assign prev_le    = le[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_link
      assign next_entry = cell_entry[i+1];
    end

    // landing point: left side in order, this cell not
    assign here[i] = prev_le && !le[i];

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[i]),
      .prev_le_i    (prev_le),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[i]),
      .le_o         (le[i])
    );
  end

  // one-hot to index
  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (here[i]) begin
        slot_idx = slot_idx | IW'(i);
      end
    end
  end

  assign slot_ext = SW'(slot_idx);

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    slot_d   = '0;
    out_d    = '0;
    if (accept) begin
      if (req_e'(req_type_i) == REQ_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
          slot_d  = slot_ext[3:0];
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
          out_d   = cell_entry[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    slot_q   <= slot_d;
    out_q    <= out_d;
  end

  assign occ_ext             = OW'(count_q);
  assign done_o              = done_q;
  assign status_o            = status_q;
  assign slot_o              = slot_q;
  assign out_kind_o          = out_q.kind;
  assign out_command_id_o    = out_q.id;
  assign out_command_value_o = out_q.value;
  assign out_priority_o      = out_q.prio;
  assign occupancy_o         = occ_ext[4:0];

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_one_landing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |-> $onehot(here))
    else $error("insert without a single landing cell");

  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the queue");

  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i && empty) |=> (status_q == ST_EMPTY && count_q == '0))
    else $error("pop on empty queue misreported");

  a_head_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > CW'(1)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
    else $error("head out of priority order");

endmodule

// File: test/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the sorted command queue
// A short table of directed words (empty pop, extreme entries, priority
// ties, full refusal) is followed by random insert/pop traffic in phases
// that drive the queue both full and empty. Every accepted word is run
// through a local sorted-store model and each done_o word is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_WORDS = 700;
  localparam int QUIET_FROM = 600;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [15:0] value;
    logic [7:0]  prio;
    logic [4:0]  occ;
  } result_t;

  typedef struct {
    req_e        req;
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [15:0] value;
    logic [7:0]  prio;
    bit          typed;
    result_t     res;
  } stim_row_t;

  localparam result_t NO_RES = '{ST_OK, 4'd0, 2'd0, 8'd0, 16'd0, 8'd0, 5'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        req_type_i;
  logic [1:0]  message_kind_i;
  logic [7:0]  command_id_i;
  logic [15:0] command_value_i;
  logic [7:0]  priority_req_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [3:0]  slot_o;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_command_id_o;
  logic [15:0] out_command_value_o;
  logic [7:0]  out_priority_o;
  logic [4:0]  occupancy_o;

  stable_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .req_type_i         (req_type_i),
    .message_kind_i     (message_kind_i),
    .command_id_i       (command_id_i),
    .command_value_i    (command_value_i),
    .priority_req_i     (priority_req_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .slot_o             (slot_o),
    .out_kind_o         (out_kind_o),
    .out_command_id_o   (out_command_id_o),
    .out_command_value_o(out_command_value_o),
    .out_priority_o     (out_priority_o),
    .occupancy_o        (occupancy_o)
  );

  // directed words: typed results only where they are obvious
  stim_row_t directed_rows [0:22] = '{
    '{REQ_POP,    2'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
      '{ST_EMPTY, 4'd0, 2'd0, 8'd0, 16'd0, 8'd0, 5'd0}},
    '{REQ_INSERT, 2'd3, 8'hFF, 16'hFFFF, 8'hFF, 1'b1,
      '{ST_OK, 4'd0, 2'd0, 8'd0, 16'd0, 8'd0, 5'd1}},
    '{REQ_INSERT, 2'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
      '{ST_OK, 4'd0, 2'd0, 8'd0, 16'd0, 8'd0, 5'd2}},
    '{REQ_INSERT, 2'd1, 8'h11, 16'h1111, 8'h80, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd2, 8'h22, 16'h2222, 8'h80, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd3, 8'h33, 16'h3333, 8'h80, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd1, 8'h44, 16'hA5A5, 8'h00, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd2, 8'h55, 16'h5A5A, 8'hFF, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd0, 8'h66, 16'h0F0F, 8'h40, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd3, 8'h77, 16'hF0F0, 8'h40, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd1, 8'h88, 16'h8001, 8'hC0, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd2, 8'h99, 16'h7FFE, 8'h01, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd0, 8'hAA, 16'hAAAA, 8'hFE, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd3, 8'hBB, 16'h5555, 8'h80, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd1, 8'hCC, 16'h1234, 8'h7F, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd2, 8'hDD, 16'hFEDC, 8'h81, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd0, 8'hEE, 16'h00FF, 8'h00, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd3, 8'hFF, 16'hFFFF, 8'h00, 1'b1,
      '{ST_FULL, 4'd0, 2'd0, 8'd0, 16'd0, 8'd0, 5'd16}},
    '{REQ_POP,    2'd3, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, NO_RES},
    '{REQ_POP,    2'd0, 8'h00, 16'h0000, 8'h00, 1'b0, NO_RES},
    '{REQ_POP,    2'd1, 8'h5A, 16'hA5A5, 8'h5A, 1'b0, NO_RES},
    '{REQ_POP,    2'd2, 8'hA5, 16'h5A5A, 8'hA5, 1'b0, NO_RES},
    '{REQ_INSERT, 2'd2, 8'h12, 16'h3456, 8'h00, 1'b0, NO_RES}
  };

  entry_t  sorted_entries [QUEUE_DEPTH];
  int      held_count;
  result_t pending_results [$];
  int      words_taken;
  int      mismatches;
  bit      use_typed;
  result_t typed_res;

  function automatic result_t queue_model_apply(req_e req, entry_t e);
    result_t r;
    int      pos;
    r = NO_RES;
    if (req == REQ_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && sorted_entries[pos].prio <= e.prio) pos++;
        for (int i = held_count; i > pos; i--) sorted_entries[i] = sorted_entries[i - 1];
        sorted_entries[pos] = e;
        held_count++;
        r.slot = pos[3:0];
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.kind  = sorted_entries[0].kind;
        r.id    = sorted_entries[0].id;
        r.value = sorted_entries[0].value;
        r.prio  = sorted_entries[0].prio;
        for (int i = 1; i < held_count; i++) sorted_entries[i - 1] = sorted_entries[i];
        held_count--;
      end
    end
    r.occ = held_count[4:0];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // check results first, then predict the word taken at this edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t model_res;
    if (done_o) begin
      got = '{status_e'(status_o), slot_o, out_kind_o, out_command_id_o,
              out_command_value_o, out_priority_o, occupancy_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word %p", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp st=%0d slot=%0d k=%0d id=%h v=%h p=%h occ=%0d",
                     $realtime, want.status, want.slot, want.kind, want.id,
                     want.value, want.prio, want.occ,
                     " | got st=%0d slot=%0d k=%0d id=%h v=%h p=%h occ=%0d",
                     got.status, got.slot, got.kind, got.id, got.value,
                     got.prio, got.occ);
        end
      end
    end
    if (rst_ni && start && !busy) begin
      model_res = queue_model_apply(req_e'(req_type_i),
                                    '{message_kind_i, command_id_i,
                                      command_value_i, priority_req_i});
      pending_results.push_back(use_typed ? typed_res : model_res);
      words_taken++;
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(req_e req, logic [1:0] kind, logic [7:0] id,
                           logic [15:0] value, logic [7:0] prio,
                           bit typed, result_t res);
    int target;
    target = words_taken + 1;
    use_typed = typed;
    typed_res = res;
    req_type_i      <= req;
    message_kind_i  <= kind;
    command_id_i    <= id;
    command_value_i <= value;
    priority_req_i  <= prio;
    start           <= 1'b1;
    do @(negedge clk_i); while (words_taken < target);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int   insert_pct;
    req_e req;
    logic [7:0] prio;
    held_count  = 0;
    words_taken = 0;
    mismatches  = 0;
    use_typed   = 1'b0;
    typed_res   = NO_RES;
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    req_type_i      <= REQ_INSERT;
    message_kind_i  <= '0;
    command_id_i    <= '0;
    command_value_i <= '0;
    priority_req_i  <= '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].req, directed_rows[i].kind, directed_rows[i].id,
                directed_rows[i].value, directed_rows[i].prio,
                directed_rows[i].typed, directed_rows[i].res);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // phases switch between insert-heavy, pop-heavy and balanced traffic to hit full and empty
      case ((i / 100) % 4)
        0: insert_pct = 80;
        1: insert_pct = 25;
        2: insert_pct = 55;
        default: insert_pct = 90;
      endcase
      if (i >= QUIET_FROM - 50 && i < QUIET_FROM) insert_pct = 10;
      if (i == RANDOM_WORDS / 2) drain_results();
      if (i < QUIET_FROM && $urandom_range(0, 4) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      req  = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP;
      // favor a few priorities so ties are common
      prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                         : 8'($urandom_range(0, 255));
      send_word(req, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), prio, 1'b0, NO_RES);
    end

    drain_results();
    repeat (5) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
test/stable_priority_queue_tb.sv
